// File: rtl/core/gcad_pkg.sv
// Shared types, constants and the special-code table for the charset decoder.
package gcad_pkg;

  localparam int unsigned MaxTokenLen = 8;
  localparam int unsigned LenW        = $clog2(MaxTokenLen + 1);
  localparam int unsigned IdxW        = $clog2(MaxTokenLen);
  localparam int unsigned BudgetW     = 16;

  localparam logic [7:0] CodeEnd      = 8'hFF;
  localparam logic [7:0] CodeDigitHi  = 8'h09;
  localparam logic [7:0] CodeUpperLo  = 8'h0A;
  localparam logic [7:0] CodeUpperHi  = 8'h23;
  localparam logic [7:0] CodeLowerLo  = 8'h24;
  localparam logic [7:0] CodeLowerHi  = 8'h3D;

  localparam logic [7:0] DigitOfs     = 8'h30;  // '0'
  localparam logic [7:0] UpperOfs     = 8'h37;  // 'A' - 0x0A
  localparam logic [7:0] LowerOfs     = 8'h3D;  // 'a' - 0x24

  localparam logic [BudgetW-1:0] BufBytesRst = 16'd64;

  // One queued item: characters left aligned, first char in the top byte.
  typedef struct packed {
    logic [LenW-1:0]                  len;
    logic [MaxTokenLen-1:0][7:0]      text;
  } gcad_tok_t;

  typedef struct packed {
    logic      hit;
    gcad_tok_t tok;
  } gcad_lookup_t;

  function automatic gcad_lookup_t mk_tok(input logic [8*MaxTokenLen-1:0] s,
                                          input logic [LenW-1:0] n);
    gcad_lookup_t r;
    r.hit      = 1'b1;
    r.tok.len  = n;
    r.tok.text = s << (8 * (MaxTokenLen - n));
    return r;
  endfunction

  function automatic gcad_lookup_t tok_lookup(input logic [7:0] code);
    gcad_lookup_t r;
    r = '0;
    case (code)
      8'hFD: r = mk_tok("[nostar]", 4'd8);
      8'hF9: r = mk_tok("[coin]", 4'd6);
      8'hFA: r = mk_tok("[star]", 4'd6);
      8'h50: r = mk_tok("[^]", 4'd3);
      8'h51: r = mk_tok("[v]", 4'd3);
      8'h52: r = mk_tok("[<]", 4'd3);
      8'h53: r = mk_tok("[>]", 4'd3);
      8'h54: r = mk_tok("[A]", 4'd3);
      8'h55: r = mk_tok("[B]", 4'd3);
      8'h56: r = mk_tok("[C]", 4'd3);
      8'h57: r = mk_tok("[Z]", 4'd3);
      8'h58: r = mk_tok("[R]", 4'd3);
      8'hD1: r = mk_tok("the", 4'd3);
      8'hD2: r = mk_tok("you", 4'd3);
      8'hE4: r = mk_tok("<->", 4'd3);
      8'hF8: r = mk_tok("...", 4'd3);
      8'hFB: r = mk_tok("[x]", 4'd3);
      8'hFC: r = mk_tok("[-]", 4'd3);
      8'hD0: r = mk_tok("  ", 4'd2);
      8'hE2: r = mk_tok(")(", 4'd2);
      8'h3E: r = mk_tok("'", 4'd1);
      8'h3F: r = mk_tok(".", 4'd1);
      8'h6F: r = mk_tok(",", 4'd1);
      8'h9E: r = mk_tok(" ", 4'd1);
      8'h9F: r = mk_tok("-", 4'd1);
      8'hE1: r = mk_tok("(", 4'd1);
      8'hE3: r = mk_tok(")", 4'd1);
      8'hE5: r = mk_tok("&", 4'd1);
      8'hE6: r = mk_tok(":", 4'd1);
      8'hF2: r = mk_tok("!", 4'd1);
      8'hF3: r = mk_tok("%", 4'd1);
      8'hF4: r = mk_tok("?", 4'd1);
      8'hF5: r = mk_tok("{", 4'd1);
      8'hF6: r = mk_tok("}", 4'd1);
      8'hF7: r = mk_tok("~", 4'd1);
      8'hFE: r = mk_tok("\n", 4'd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/gcad_front.sv
// Front end: accepts code bytes, tracks budget and string end, builds queue items.
module gcad_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               code_i,
  input  logic                     start_req_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output gcad_pkg::gcad_tok_t      push_tok_o
);
  import gcad_pkg::*;

  logic [BudgetW-1:0] buf_bytes_q;
  logic [BudgetW-1:0] budget_q, budget_d, budget_eff;
  logic               done_q, done_d, done_eff;
  logic               accept;
  logic               emit;
  gcad_lookup_t       lk;
  gcad_tok_t          tok;
  logic [LenW-1:0]    cut_len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // start reloads before the byte itself is looked at
  always_comb begin
    if (start_req_i) begin
      budget_eff = (buf_bytes_q == '0) ? '0 : buf_bytes_q - 1'b1;
      done_eff   = 1'b0;
    end else begin
      budget_eff = budget_q;
      done_eff   = done_q;
    end
  end

  assign lk      = tok_lookup(code_i);
  assign cut_len = (budget_eff < BudgetW'(lk.tok.len)) ? budget_eff[LenW-1:0] : lk.tok.len;

  always_comb begin
    budget_d = budget_eff;
    done_d   = done_eff;
    emit     = 1'b0;
    tok      = '0;
    if (done_eff) begin
      // ended string: byte dropped
    end else if (code_i == CodeEnd || budget_eff == '0) begin
      done_d = 1'b1;
    end else if (lk.hit) begin
      tok      = lk.tok;
      tok.len  = cut_len;
      emit     = 1'b1;
      budget_d = budget_eff - BudgetW'(cut_len);
    end else begin
      tok.len  = LenW'(1);
      budget_d = budget_eff - 1'b1;
      if (code_i <= CodeDigitHi) begin
        tok.text[MaxTokenLen-1] = code_i + DigitOfs;
        emit = 1'b1;
      end else if (code_i >= CodeUpperLo && code_i <= CodeUpperHi) begin
        tok.text[MaxTokenLen-1] = code_i + UpperOfs;
        emit = 1'b1;
      end else if (code_i >= CodeLowerLo && code_i <= CodeLowerHi) begin
        tok.text[MaxTokenLen-1] = code_i + LowerOfs;
        emit = 1'b1;
      end
    end
  end

  assign push_o     = accept && emit;
  assign push_tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_bytes_q <= BufBytesRst;
      budget_q    <= '0;
      done_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        buf_bytes_q <= cfg_wdata_i;
      end
      if (accept) begin
        budget_q <= budget_d;
        done_q   <= done_d;
      end
    end
  end

endmodule

// File: rtl/core/gcad_queue.sv
// Short register queue of decoded items between front and back ends.
module gcad_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gcad_pkg::gcad_tok_t  push_tok_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output gcad_pkg::gcad_tok_t  head_tok_o
);
  import gcad_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gcad_tok_t        slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_tok_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/gcad_back.sv
// Back end: walks the head item one character per output handshake.
module gcad_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  gcad_pkg::gcad_tok_t  head_tok_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           ascii_char_o,
  output logic                 last_o
);
  import gcad_pkg::*;

  logic [IdxW-1:0] idx_q;
  logic            accept;

  assign out_valid_o  = head_valid_i;
  assign ascii_char_o = head_tok_i.text[IdxW'(MaxTokenLen - 1) - idx_q];
  assign last_o       = ({1'b0, idx_q} == LenW'(head_tok_i.len - 1'b1));
  assign accept       = out_valid_o && out_ready_i;
  assign pop_o        = accept && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (accept) begin
      idx_q <= last_o ? '0 : idx_q + 1'b1;
    end
  end

endmodule

// File: rtl/core/game_charset_to_ascii_decoder.sv
// Top level of the game charset to ASCII decoder.
// Takes one game-text byte per input item and returns its ASCII characters, one per
// output item, with last_o on the final character of each byte. An input item is
// taken every cycle while the item queue (QueueDepth entries) has room; a byte that
// decodes to several characters holds the output side until all of them are taken,
// and the queue fills and stalls the input when such bytes arrive in a run. Bytes that
// emit nothing (terminator, unknown code, ended string) are taken with no output.
// The first character of a byte is offered once its item reaches the queue head.
// buffer_bytes (cfg_wdata_i) takes effect at the next start_req_i.
module game_charset_to_ascii_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  code_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_o
);
  import gcad_pkg::*;

  logic      q_full, push, pop, head_valid;
  gcad_tok_t push_tok, head_tok;

  gcad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_i      (code_i),
    .start_req_i (start_req_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_tok_o  (push_tok)
  );

  gcad_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_tok_i   (push_tok),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_tok_o   (head_tok)
  );

  gcad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_tok_i   (head_tok),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o)
  );

endmodule
